/* rtl/ssul_pkg.sv */
package ssul_pkg;

   localparam int DefMaxItems  = 32;
   localparam int DefMaxTarget = 1023;
   localparam int ValueWidth   = 16;
   localparam int LimitWidth   = 10;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_BUILD,
      ST_BEST,
      ST_WALK,
      ST_EMIT,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic [ValueWidth-1:0] chosen_item;
      logic                  item_valid;
      logic [LimitWidth-1:0] best_sum;
      logic                  too_many;
      logic                  last_result;
   } rsp_type;

endpackage

/* rtl/ssul_if.sv */
interface ssul_req_if;
   import ssul_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ValueWidth-1:0] item_value;
   logic                  last_item;
   modport source (output valid, item_value, last_item, input ready);
   modport sink (input valid, item_value, last_item, output ready);
endinterface

interface ssul_rsp_if;
   import ssul_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ValueWidth-1:0] chosen_item;
   logic                  item_valid;
   logic [LimitWidth-1:0] best_sum;
   logic                  too_many;
   logic                  last_result;
   modport source (output valid, chosen_item, item_valid, best_sum, too_many, last_result,
                   input ready);
   modport sink (input valid, chosen_item, item_valid, best_sum, too_many, last_result,
                 output ready);
endinterface

interface ssul_csr_if;
   import ssul_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [LimitWidth-1:0] target_limit;
   modport source (output valid, target_limit, input ready);
   modport sink (input valid, target_limit, output ready);
endinterface

/* rtl/ssul_reach_mem.sv */
// Suffix reachability memory: one row per suffix, one bit per sum.
// Rows are one entry wide (MaxTarget+1 bits); one write and one read port.
module ssul_reach_mem #(
   parameter int MaxItems  = ssul_pkg::DefMaxItems,
   parameter int MaxTarget = ssul_pkg::DefMaxTarget,
   localparam int RowW = $clog2(MaxItems + 1)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [RowW-1:0]      wr_row,
   input  logic [MaxTarget:0]   wr_data,
   input  logic [RowW-1:0]      rd_row,
   output logic [MaxTarget:0]   rd_data
);
   logic [MaxTarget:0] mem [MaxItems+1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      rd_data <= mem[rd_row];
   end
endmodule

/* rtl/ssul_item_mem.sv */
// Item value store, written while loading, read one entry per step.
module ssul_item_mem #(
   parameter int MaxItems = ssul_pkg::DefMaxItems,
   localparam int AddrW = (MaxItems > 1) ? $clog2(MaxItems) : 1
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [AddrW-1:0]                wr_addr,
   input  logic [ssul_pkg::ValueWidth-1:0] wr_data,
   input  logic [AddrW-1:0]                rd_addr,
   output logic [ssul_pkg::ValueWidth-1:0] rd_data
);
   import ssul_pkg::*;
   logic [ValueWidth-1:0] mem [MaxItems];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/subset_sum_under_limit.sv */
// Subset sum under a limit. Items load one per transaction (MaxItems
// stored, later ones dropped and flagged by too_many). The transaction with
// last_item starts solving, and the block is not ready until the last result
// is taken. Solving writes the empty-suffix row, then builds one suffix
// reachability row per item through a shared shift-and-OR unit over a row
// memory, each row in a read, wait and write phase. A best-sum search follows:
// after a read wait, one sum per cycle from the limit downward (up to
// MaxTarget+1 sums). Then comes a walk over the items in read, wait and check
// phases, with a result handshake for each result. Rows are full width, so no
// clearing pass is needed; a row is written before it is read.
module subset_sum_under_limit #(
   parameter int MaxItems  = ssul_pkg::DefMaxItems,
   parameter int MaxTarget = ssul_pkg::DefMaxTarget
) (
   input logic        clock,
   input logic        reset,
   ssul_req_if.sink   req,
   ssul_rsp_if.source rsp,
   ssul_csr_if.sink   csr
);
   import ssul_pkg::*;

   localparam int RowW  = $clog2(MaxItems + 1);
   localparam int AddrW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
   localparam int SumW  = $clog2(MaxTarget + 1);
   localparam int SW    = (SumW > LimitWidth) ? SumW : LimitWidth;

   state_type state_ff, state_in;
   logic [LimitWidth-1:0] limit_ff;
   logic [RowW-1:0]       count_ff, count_in;
   logic                  over_ff, over_in;
   logic [RowW-1:0]       idx_ff, idx_in;
   logic [1:0]            ph_ff, ph_in;
   logic [SW-1:0]         eff_limit;
   logic [SW-1:0]         sum_ff, sum_in;
   logic [SW-1:0]         best_ff, best_in;
   logic [SW-1:0]         rem_ff, rem_in;
   rsp_type               out_ff, out_in;

   logic                  rm_we;
   logic [RowW-1:0]       rm_wrow, rm_rrow;
   logic [MaxTarget:0]    rm_wdata, rm_rdata, mask, shifted;
   logic [AddrW-1:0]      im_waddr, im_raddr;
   logic [ValueWidth-1:0] im_rdata;

   // effective limit
   always_comb begin
      eff_limit = SW'(limit_ff);
      if ({{(32-SW){1'b0}}, eff_limit} > MaxTarget) eff_limit = SW'(MaxTarget);
   end

   ssul_item_mem #(.MaxItems(MaxItems)) u_items (
      .clock(clock), .wr_en(req.valid && req.ready && (count_ff < RowW'(MaxItems))),
      .wr_addr(im_waddr), .wr_data(req.item_value), .rd_addr(im_raddr), .rd_data(im_rdata)
   );
   assign im_waddr = count_ff[AddrW-1:0];

   ssul_reach_mem #(.MaxItems(MaxItems), .MaxTarget(MaxTarget)) u_reach (
      .clock(clock), .wr_en(rm_we), .wr_row(rm_wrow), .wr_data(rm_wdata),
      .rd_row(rm_rrow), .rd_data(rm_rdata)
   );

   // shared shift-and-OR unit, masked to sums up to the limit
   always_comb begin
      mask = '0;
      for (int s = 0; s <= MaxTarget; s++) begin
         mask[s] = (s <= int'(eff_limit));
      end
      if (im_rdata > ValueWidth'(MaxTarget)) shifted = '0;
      else shifted = rm_rdata << im_rdata;
   end

   assign csr.ready = (state_ff == ST_LOAD);
   assign req.ready = (state_ff == ST_LOAD);
   assign rsp.valid = (state_ff == ST_EMIT) || (state_ff == ST_EMPTY);
   assign rsp.chosen_item = out_ff.chosen_item;
   assign rsp.item_valid  = out_ff.item_valid;
   assign rsp.best_sum    = out_ff.best_sum;
   assign rsp.too_many    = out_ff.too_many;
   assign rsp.last_result = out_ff.last_result;

   // memory port controls
   always_comb begin
      rm_we    = 1'b0;
      rm_wrow  = idx_ff;
      rm_wdata = '0;
      rm_rrow  = idx_ff;
      im_raddr = AddrW'(idx_ff);
      case (state_ff)
         ST_CLEAR: begin
            // empty suffix reaches only zero
            rm_we    = 1'b1;
            rm_wrow  = count_ff;
            rm_wdata = (MaxTarget+1)'(1);
         end
         ST_BUILD: begin
            rm_rrow  = idx_ff;
            im_raddr = AddrW'(idx_ff - 1'b1);
            if (ph_ff == 2'd2) begin
               rm_we    = 1'b1;
               rm_wrow  = idx_ff - 1'b1;
               rm_wdata = (rm_rdata | shifted) & mask;
            end
         end
         ST_BEST: begin
            rm_rrow = '0;
         end
         ST_WALK: begin
            rm_rrow  = idx_ff + 1'b1;
            im_raddr = AddrW'(idx_ff);
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      over_in  = over_ff;
      idx_in   = idx_ff;
      ph_in    = ph_ff;
      sum_in   = sum_ff;
      best_in  = best_ff;
      rem_in   = rem_ff;
      out_in   = out_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req.valid) begin
               if (count_ff < RowW'(MaxItems)) count_in = count_ff + 1'b1;
               else over_in = 1'b1;
               if (req.last_item) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            idx_in   = count_ff;
            ph_in    = 2'd0;
            state_in = (count_ff == '0) ? ST_BEST : ST_BUILD;
            sum_in   = eff_limit;
         end
         ST_BUILD: begin
            ph_in = ph_ff + 1'b1;
            if (ph_ff == 2'd2) begin
               ph_in  = 2'd0;
               idx_in = idx_ff - 1'b1;
               if (idx_ff == RowW'(1)) state_in = ST_BEST;
            end
         end
         ST_BEST: begin
            ph_in = (ph_ff == 2'd2) ? 2'd2 : ph_ff + 1'b1;
            if (ph_ff == 2'd2) begin
               if (rm_rdata[sum_ff[SumW-1:0]] || sum_ff == '0) begin
                  best_in  = rm_rdata[sum_ff[SumW-1:0]] ? sum_ff : '0;
                  rem_in   = rm_rdata[sum_ff[SumW-1:0]] ? sum_ff : '0;
                  idx_in   = '0;
                  ph_in    = 2'd0;
                  state_in = (count_ff == '0) ? ST_EMPTY : ST_WALK;
                  out_in   = '{chosen_item: '0, item_valid: 1'b0,
                               best_sum: LimitWidth'(best_in), too_many: over_ff,
                               last_result: 1'b1};
               end else begin
                  sum_in = sum_ff - 1'b1;
               end
            end
         end
         ST_WALK: begin
            ph_in = ph_ff + 1'b1;
            if (ph_ff == 2'd2) begin
               ph_in  = 2'd0;
               idx_in = idx_ff + 1'b1;
               if (!rm_rdata[rem_ff[SumW-1:0]] && {{(SW){1'b0}}, im_rdata} <=
                   {{(ValueWidth){1'b0}}, rem_ff}) begin
                  rem_in   = rem_ff - SW'(im_rdata);
                  out_in   = '{chosen_item: im_rdata, item_valid: 1'b1,
                               best_sum: LimitWidth'(best_ff), too_many: over_ff,
                               last_result: (rem_in == '0) ||
                                            (idx_ff + 1'b1 == count_ff)};
                  state_in = ST_EMIT;
               end else if (idx_ff + 1'b1 == count_ff) begin
                  state_in = ST_EMPTY;
               end
            end
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               if (out_ff.last_result) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  over_in  = 1'b0;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_EMPTY: begin
            if (rsp.ready) begin
               state_in = ST_LOAD;
               count_in = '0;
               over_in  = 1'b0;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         limit_ff <= '0;
         count_ff <= '0;
         over_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         over_ff  <= over_in;
         if (csr.valid && csr.ready) limit_ff <= csr.target_limit;
      end
      idx_ff  <= idx_in;
      ph_ff   <= ph_in;
      sum_ff  <= sum_in;
      best_ff <= best_in;
      rem_ff  <= rem_in;
      out_ff  <= out_in;
   end
endmodule

/* test/tb_subset_sum_under_limit.sv */
`timescale 1ns / 1ps

module tb_subset_sum_under_limit;
   import ssul_pkg::*;

   localparam int MaxItems  = DefMaxItems;
   localparam int MaxTarget = DefMaxTarget;
   localparam int CycleLimit = 2000000;
   localparam int DrainCycles = 4000;

   logic clock;
   logic reset;

   ssul_req_if req ();
   ssul_rsp_if rsp ();
   ssul_csr_if csr ();

   subset_sum_under_limit uut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source),
      .csr  (csr.sink)
   );

   // predictor state
   logic [LimitWidth-1:0] limit_reg;
   logic [ValueWidth-1:0] set_items[$];
   logic                  set_overflow;
   rsp_type               expected_picks[$];

   int  error_count;
   int  cycle_count = 0;
   bit  hold_off;
   int  hold_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // global timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb_subset_sum_under_limit NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $realtime, what);
      error_count++;
   endtask

   // solve one set: suffix reachability, then in-order reconstruction
   task automatic predict_set();
      bit    reach[][];
      int    n, lim, best, remain, v, picks;
      rsp_type r;
      n = set_items.size();
      lim = (limit_reg < MaxTarget) ? limit_reg : MaxTarget;
      reach = new[n + 1];
      foreach (reach[i]) reach[i] = new[lim + 1];
      reach[n][0] = 1'b1;
      for (int i = n - 1; i >= 0; i--) begin
         v = set_items[i];
         for (int s = 0; s <= lim; s++) begin
            reach[i][s] = reach[i + 1][s];
            if (v <= s && reach[i + 1][s - v]) reach[i][s] = 1'b1;
         end
      end
      best = 0;
      for (int s = lim; s >= 0; s--) begin
         if (reach[0][s]) begin
            best = s;
            break;
         end
      end
      remain = best;
      picks = 0;
      for (int i = 0; i < n; i++) begin
         v = set_items[i];
         if (reach[i + 1][remain]) continue;
         if (v <= remain) begin
            remain -= v;
            r.chosen_item = ValueWidth'(v);
            r.item_valid = 1'b1;
            r.best_sum = LimitWidth'(best);
            r.too_many = set_overflow;
            r.last_result = 1'b0;
            expected_picks = {expected_picks, r};
            picks++;
         end
      end
      if (picks == 0) begin
         r.chosen_item = '0;
         r.item_valid = 1'b0;
         r.best_sum = LimitWidth'(best);
         r.too_many = set_overflow;
         r.last_result = 1'b0;
         expected_picks = {expected_picks, r};
      end
      expected_picks[expected_picks.size() - 1].last_result = 1'b1;
      set_items.delete();
      set_overflow = 1'b0;
   endtask

   // send one item transaction after a random gap; valid stays up between
   // back-to-back items
   task automatic send_item(input logic [ValueWidth-1:0] value, input bit last,
                            input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12));
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.item_value <= value;
      req.last_item <= last;
      do @(posedge clock); while (!req.ready);
      if (set_items.size() < MaxItems) set_items = {set_items, value};
      else set_overflow = 1'b1;
      if (last) predict_set();
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (expected_picks.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LimitWidth-1:0] value);
      wait_idle();
      csr.valid <= 1'b1;
      csr.target_limit <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      limit_reg = value;
   endtask

   function automatic logic [ValueWidth-1:0] rand_value(input int lim);
      case ($urandom_range(0, 9))
         0: return ValueWidth'($urandom_range(0, 65535));
         1: return 16'd0;
         2: return ValueWidth'(lim + 1 + $urandom_range(0, 5));
         default: return ValueWidth'($urandom_range(0, (lim / 3) + 1));
      endcase
   endfunction

   task automatic send_set(input int count, input int lim);
      for (int i = 0; i < count; i++) send_item(rand_value(lim), i == count - 1);
   endtask

   // response side: random stalls, long hold when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_off) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else if (rsp.valid && rsp.ready) begin
         hold_cycles <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_picks.size() == 0) begin
            report_mismatch("result transaction with nothing expected");
         end else begin
            want = expected_picks.pop_front();
            if (rsp.chosen_item !== want.chosen_item)
               report_mismatch($sformatf("chosen_item %0d want %0d",
                                         rsp.chosen_item, want.chosen_item));
            if (rsp.item_valid !== want.item_valid)
               report_mismatch($sformatf("item_valid %0b want %0b",
                                         rsp.item_valid, want.item_valid));
            if (rsp.best_sum !== want.best_sum)
               report_mismatch($sformatf("best_sum %0d want %0d",
                                         rsp.best_sum, want.best_sum));
            if (rsp.too_many !== want.too_many)
               report_mismatch($sformatf("too_many %0b want %0b",
                                         rsp.too_many, want.too_many));
            if (rsp.last_result !== want.last_result)
               report_mismatch($sformatf("last_result %0b want %0b",
                                         rsp.last_result, want.last_result));
         end
      end
   end

   task automatic test_directed();
      write_limit(10'd0);
      send_item(16'd0, 1'b1);
      send_item(16'd5, 1'b1);
      write_limit(10'd1023);
      send_item(16'hFFFF, 1'b0);
      send_item(16'd1023, 1'b0);
      send_item(16'd1, 1'b1);
      send_item(16'd512, 1'b0);
      send_item(16'd511, 1'b0);
      send_item(16'd512, 1'b1);
      write_limit(10'd20);
      send_item(16'd10, 1'b0);
      send_item(16'd10, 1'b0);
      send_item(16'd20, 1'b0);
      send_item(16'd7, 1'b1);
      send_item(16'h5555, 1'b0);
      send_item(16'hAAAA, 1'b1);
   endtask

   task automatic test_overflow();
      write_limit(10'd100);
      for (int i = 0; i < MaxItems + 3; i++)
         send_item(ValueWidth'($urandom_range(0, 40)), i == MaxItems + 2);
      // exactly MaxItems, no overflow
      for (int i = 0; i < MaxItems; i++)
         send_item(ValueWidth'($urandom_range(0, 40)), i == MaxItems - 1);
   endtask

   task automatic test_random();
      int sent;
      int lim;
      int count;
      sent = 0;
      while (sent < 150) begin
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
               0: lim = 0;
               1: lim = 1023;
               default: lim = $urandom_range(1, 300);
            endcase
            write_limit(LimitWidth'(lim));
         end
         lim = limit_reg;
         count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MaxItems) :
                 $urandom_range(1, 8);
         send_set(count, lim);
         sent += count;
      end
   endtask

   task automatic test_backpressure();
      write_limit(10'd200);
      hold_off = 1'b1;
      fork
         begin
            for (int k = 0; k < 3; k++)
               for (int i = 0; i < 6; i++)
                  send_item(ValueWidth'($urandom_range(0, 60)), i == 5, 1'b1);
         end
         begin
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
      join
      // pause until everything drained, then a set back to back
      wait_idle();
      for (int i = 0; i < 5; i++)
         send_item(ValueWidth'($urandom_range(0, 90)), i == 4, 1'b1);
   endtask

   initial begin
      error_count = 0;
      hold_off = 1'b0;
      limit_reg = '0;
      set_overflow = 1'b0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.item_value = '0;
      req.last_item = 1'b0;
      csr.valid = 1'b0;
      csr.target_limit = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_overflow();
      test_backpressure();
      test_random();

      req.valid <= 1'b0;
      while (expected_picks.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_subset_sum_under_limit OK");
      end else begin
         $display("tb_subset_sum_under_limit NOT OK");
      end
      $finish;
   end

endmodule
